@@ design/assert_macros.svh @@
// Assertion helpers for the RTL files; only the decoder unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ design/rbpd_pkg.sv @@
`default_nettype none

package rbpd_pkg;

  localparam logic [7:0] MarkFg = 8'hFF;
  localparam logic [7:0] MarkBg = 8'h00;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFgColor = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBgColor = 1'b1;

  localparam logic [2:0] LastBit = 3'd7;

  typedef logic [15:0] color_t;
  typedef logic [10:0] count_t;

endpackage

`default_nettype wire

@@ design/rle_bitmap_pixel_decoder_unit.sv @@
// Channel   Direction  Payload
// s_*       in         tdata[7:0] code_byte
// m_*       out        tdata[15:0] pixel_color, tdata[26:16] repeat_count; tlast last_of_item
// cfg_*     in         index 0 fg_color, index 1 bg_color
//
// A literal byte holds the work register until its last bit is out, one pixel result per cycle
// unless the output stalls; a new byte is taken as the previous one finishes or when none waits.
// The output register decouples the sides: a stalled result holds while work waits.
// Synchronous active-high reset clears the decoder to expecting a code byte.
`default_nettype none

`include "assert_macros.svh"

module rle_bitmap_pixel_decoder_unit (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // [7:0] code_byte
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [31:0]                  m_tdata,   // [15:0] pixel_color, [26:16] repeat_count
  output logic                         m_tlast,   // last_of_item
  input  wire                          cfg_we,
  input  wire  [rbpd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  [15:0]                  cfg_data
);
  import rbpd_pkg::*;

  color_t     fg_color;
  color_t     bg_color;
  logic       awaiting_count;
  logic       run_is_fg;

  logic       wvalid;
  logic [7:0] wbyte;
  logic       wlit;
  logic       wfg;
  logic [2:0] idx;

  color_t     out_color;
  count_t     out_count;

  logic       out_load;
  logic       step;
  logic       done;
  logic       accept;
  logic       is_marker;
  logic       load_work;
  logic       bit_set;

  always_comb begin
    out_load  = !m_tvalid || m_tready;
    step      = wvalid && out_load;
    done      = step && (!wlit || idx == LastBit);
    s_tready  = !wvalid || done;
    accept    = s_tvalid && s_tready;
    is_marker = (s_tdata == MarkFg) || (s_tdata == MarkBg);
    load_work = accept && (awaiting_count ? (s_tdata != 8'd0) : !is_marker);
    bit_set   = wbyte[LastBit - idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 16'h0000;
      bg_color <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        RegFgColor: fg_color <= cfg_data;
        RegBgColor: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_count <= 1'b0;
      run_is_fg      <= 1'b0;
    end else if (accept) begin
      if (awaiting_count) begin
        awaiting_count <= 1'b0;
      end else if (is_marker) begin
        awaiting_count <= 1'b1;
        run_is_fg      <= (s_tdata == MarkFg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
    end else if (load_work) begin
      wvalid <= 1'b1;
    end else if (done) begin
      wvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_work) begin
      wbyte <= s_tdata;
      wlit  <= !awaiting_count;
      wfg   <= run_is_fg;
      idx   <= 3'd0;
    end else if (step && wlit) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= wvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (wlit) begin
        out_color <= bit_set ? fg_color : bg_color;
        out_count <= 11'd1;
        m_tlast   <= (idx == LastBit);
      end else begin
        out_color <= wfg ? fg_color : bg_color;
        out_count <= {wbyte, 3'b000};
        m_tlast   <= 1'b1;
      end
    end
  end

  assign m_tdata = {5'd0, out_count, out_color};

  `CHK_SAME(a_count_nonzero, clk, rst, m_tvalid, m_tdata[26:16] != 11'd0)
  `CHK_SAME(a_run_is_last, clk, rst, m_tvalid && m_tdata[26:16] != 11'd1, m_tlast)
  `CHK_SAME(a_literal_blocks, clk, rst, wvalid && wlit && idx != LastBit, !s_tready)
  `CHK_NEXT(a_marker_arms, clk, rst, accept && !awaiting_count && is_marker, awaiting_count)

endmodule

`default_nettype wire
